/* design/cnbw_pkg.sv */
package cnbw_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int WORK_FRAC = 24;

  localparam logic [31:0] HASH_A = 32'd374761393;
  localparam logic [31:0] HASH_B = 32'd668265263;
  localparam logic [31:0] HASH_C = 32'd1274126177;

  localparam int NCELL = 9;
  localparam int NBIOME = 4;

  localparam int DELTA_W = WORK_FRAC + 2;
  localparam int SQ_W = 2 * DELTA_W - 2;
  localparam int DIST_W = SQ_W + 1;
  localparam int S_W = 36;
  localparam int R_W = S_W / 2;
  localparam int T_W = S_W + R_W;
  localparam int WRAW_W = 35;
  localparam int SUM_W = WRAW_W + 2;
  localparam int WT_W = 17;

  localparam logic [S_W-1:0] EPS_Q32 = S_W'(429497);
  localparam logic [63:0] RAW_NUM = 64'h8000_0000_0000_0000;

  localparam int FRONT_STAGES = 8;
  localparam int LATENCY = FRONT_STAGES + R_W + 1 + WRAW_W + 2 + WT_W;
  localparam int PRES_DELAY = R_W + 1 + WRAW_W;

  function automatic logic [31:0] cell_ofs(input int ddx, input int ddz);
    longint v;
    v = longint'(ddx) * longint'(HASH_A) + longint'(ddz) * longint'(HASH_B);
    return v[31:0];
  endfunction

endpackage

/* design/cellular_noise_biome_weights.sv */
// Cellular biome blend weights: each transaction on the slave side carries one sample
// point and yields one transaction on the master side with four normalized Q1.16
// weights, one per biome. The block takes a new point every cycle while the skid register
// is empty; its pipeline runs through the eighteen-step square root, the 35-step raw-weight
// divider and the 17-step normalizing divider, all fully pipelined, plus the output register. A
// skid register at the output lets the pipe advance one more time while a result
// waits; input stalls only when both output and skid are full.
module cellular_noise_biome_weights
  import cnbw_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // pos_x[31:0], pos_z[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // weight_0, weight_1, weight_2, weight_3 (17 bits each), pad
);

  logic en;
  logic skid_valid;
  logic [4*WT_W-1:0] skid_data;

  assign en = !skid_valid;
  assign s_tready = en;

  // stage 1
  logic [31:0] pos_x, pos_z, cellx, cellz;
  logic [WORK_FRAC-1:0] fx0, fz0;
  logic [31:0] s1_cxa, s1_czb;
  logic [WORK_FRAC-1:0] s1_fx, s1_fz;

  assign pos_x = s_tdata[31:0];
  assign pos_z = s_tdata[63:32];
  assign cellx = 32'($signed(pos_x) >>> COORD_FRAC_BITS);
  assign cellz = 32'($signed(pos_z) >>> COORD_FRAC_BITS);
  assign fx0 = WORK_FRAC'(pos_x[COORD_FRAC_BITS-1:0]) << (WORK_FRAC - COORD_FRAC_BITS);
  assign fz0 = WORK_FRAC'(pos_z[COORD_FRAC_BITS-1:0]) << (WORK_FRAC - COORD_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cxa <= cellx * HASH_A;
      s1_czb <= cellz * HASH_B;
      s1_fx  <= fx0;
      s1_fz  <= fz0;
    end
  end

  logic [WORK_FRAC-1:0] s2_fx, s2_fz, s3_fx, s3_fz;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_fx <= s1_fx;
      s2_fz <= s1_fz;
      s3_fx <= s2_fx;
      s3_fz <= s2_fz;
    end
  end

  logic [31:0] s2_h1 [NCELL];
  logic [31:0] s3_h2 [NCELL];
  logic signed [DELTA_W-1:0] s4_dx [NCELL];
  logic signed [DELTA_W-1:0] s4_dz [NCELL];
  logic [1:0] s4_id [NCELL];
  logic [SQ_W-1:0] s5_dxx [NCELL];
  logic [SQ_W-1:0] s5_dzz [NCELL];
  logic [1:0] s5_id [NCELL];
  logic [DIST_W-1:0] s6_d [NCELL];
  logic [1:0] s6_id [NCELL];

  genvar c;
  generate
    for (c = 0; c < NCELL; c++) begin : g_cell
      localparam int DDX = (c % 3) - 1;
      localparam int DDZ = (c / 3) - 1;
      localparam logic [31:0] OFS = cell_ofs(DDX, DDZ);
      localparam logic signed [DELTA_W:0] BASE_X = (DELTA_W + 1)'(DDX * (1 << WORK_FRAC));
      localparam logic signed [DELTA_W:0] BASE_Z = (DELTA_W + 1)'(DDZ * (1 << WORK_FRAC));
      logic [31:0] x, h1, h;
      logic [WORK_FRAC-1:0] ox, oz;
      logic signed [DELTA_W:0] dxw, dzw;
      logic signed [2*DELTA_W-1:0] sqx, sqz;

      assign x  = s1_cxa + s1_czb + OFS;
      assign h1 = x ^ 32'($signed(x) >>> 13);
      assign h  = s3_h2[c] ^ 32'($signed(s3_h2[c]) >>> 16);
      assign ox = WORK_FRAC'(h[15:0]) << (WORK_FRAC - 16);
      assign oz = WORK_FRAC'(h[31:16]) << (WORK_FRAC - 16);
      assign dxw = BASE_X + $signed({3'b000, ox}) - $signed({3'b000, s3_fx});
      assign dzw = BASE_Z + $signed({3'b000, oz}) - $signed({3'b000, s3_fz});
      assign sqx = s4_dx[c] * s4_dx[c];
      assign sqz = s4_dz[c] * s4_dz[c];

      always_ff @(posedge clk) begin
        if (en) begin
          s2_h1[c]  <= h1;
          s3_h2[c]  <= s2_h1[c] * HASH_C;
          s4_dx[c]  <= dxw[DELTA_W-1:0];
          s4_dz[c]  <= dzw[DELTA_W-1:0];
          s4_id[c]  <= h[1:0];
          s5_dxx[c] <= sqx[SQ_W-1:0];
          s5_dzz[c] <= sqz[SQ_W-1:0];
          s5_id[c]  <= s4_id[c];
          s6_d[c]   <= {1'b0, s5_dxx[c]} + {1'b0, s5_dzz[c]};
          s6_id[c]  <= s5_id[c];
        end
      end
    end
  endgenerate

  // per-biome minimum over groups of three cells
  logic [DIST_W-1:0] g_best [3][NBIOME];
  logic              g_pr   [3][NBIOME];
  logic [DIST_W-1:0] s7_best [3][NBIOME];
  logic              s7_pr   [3][NBIOME];

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int b = 0; b < NBIOME; b++) begin
        g_best[g][b] = '0;
        g_pr[g][b] = 1'b0;
        for (int j = 0; j < 3; j++) begin
          if (s6_id[3*g+j] == 2'(b) && (!g_pr[g][b] || s6_d[3*g+j] < g_best[g][b])) begin
            g_best[g][b] = s6_d[3*g+j];
            g_pr[g][b] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_best <= g_best;
      s7_pr   <= g_pr;
    end
  end

  logic [DIST_W-1:0] f_best [NBIOME];
  logic [NBIOME-1:0] f_pr;
  logic [S_W-1:0] s8_s [NBIOME];
  logic [NBIOME-1:0] s8_pr;

  always_comb begin
    for (int b = 0; b < NBIOME; b++) begin
      f_best[b] = '0;
      f_pr[b] = 1'b0;
      for (int g = 0; g < 3; g++) begin
        if (s7_pr[g][b] && (!f_pr[b] || s7_best[g][b] < f_best[b])) begin
          f_best[b] = s7_best[g][b];
          f_pr[b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < NBIOME; b++) begin
        s8_s[b] <= S_W'(f_best[b] >> 16) + EPS_Q32;
      end
      s8_pr <= f_pr;
    end
  end

  logic [NBIOME-1:0] pr_d;
  cnbw_delay #(.W(NBIOME), .DEPTH(PRES_DELAY)) u_pres (
    .clk(clk), .rst(rst), .en(en), .din(s8_pr), .dout(pr_d)
  );

  logic [WRAW_W-1:0] w_raw [NBIOME];
  logic [WRAW_W-1:0] s10_w [NBIOME];
  logic [WRAW_W-1:0] s11_w [NBIOME];
  logic [SUM_W-1:0]  s11_sum;
  logic [WT_W-1:0]   wt [NBIOME];

  genvar b;
  generate
    for (b = 0; b < NBIOME; b++) begin : g_biome
      logic [R_W-1:0] r;
      logic [S_W-1:0] s_d;
      logic [T_W-1:0] s9_t;

      cnbw_isqrt #(.SW(S_W)) u_sqrt (
        .clk(clk), .en(en), .operand(s8_s[b]), .root(r), .operand_out(s_d)
      );

      always_ff @(posedge clk) begin
        if (en) begin
          s9_t <= s_d * r;
        end
      end

      cnbw_div #(.NW(64), .DW(T_W), .QW(WRAW_W)) u_raw (
        .clk(clk), .en(en), .num(RAW_NUM), .den(s9_t), .quo(w_raw[b])
      );

      always_ff @(posedge clk) begin
        if (en) begin
          s10_w[b] <= pr_d[b] ? w_raw[b] : '0;
          s11_w[b] <= s10_w[b];
        end
      end

      cnbw_div #(.NW(WRAW_W + 16), .DW(SUM_W), .QW(WT_W)) u_norm (
        .clk(clk), .en(en), .num({s11_w[b], 16'h0000}), .den(s11_sum), .quo(wt[b])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      s11_sum <= SUM_W'(s10_w[0]) + SUM_W'(s10_w[1]) + SUM_W'(s10_w[2]) + SUM_W'(s10_w[3]);
    end
  end

  logic pv;
  cnbw_delay #(.W(1), .DEPTH(LATENCY)) u_valid (
    .clk(clk), .rst(rst), .en(en), .din(s_tvalid), .dout(pv)
  );

  logic [4*WT_W-1:0] pdata;
  assign pdata = {wt[3], wt[2], wt[1], wt[0]};

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (m_tready) begin
          m_tdata    <= {4'b0000, skid_data};
          skid_valid <= 1'b0;
        end
      end else if (pv) begin
        if (!m_tvalid || m_tready) begin
          m_tdata  <= {4'b0000, pdata};
          m_tvalid <= 1'b1;
        end else begin
          skid_data  <= pdata;
          skid_valid <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  logic [WT_W+1:0] wsum;
  assign wsum = (WT_W + 2)'(m_tdata[16:0]) + (WT_W + 2)'(m_tdata[33:17])
              + (WT_W + 2)'(m_tdata[50:34]) + (WT_W + 2)'(m_tdata[67:51]);

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid holds data with output empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without output stall");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (wsum <= (WT_W + 2)'(65536) && wsum >= (WT_W + 2)'(65533)))
    else $error("weights do not sum to one");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:68] == 4'b0000) else $error("pad bits set");

endmodule

/* design/cnbw_delay.sv */
module cnbw_delay
  import cnbw_pkg::*;
#(
  parameter int W = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        taps[i] <= '0;
      end
    end else if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

/* design/cnbw_isqrt.sv */
module cnbw_isqrt
  import cnbw_pkg::*;
#(
  parameter int SW = S_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SW-1:0]   operand,
  output logic [SW/2-1:0] root,
  output logic [SW-1:0]   operand_out
);

  localparam int RW = SW / 2;

  logic [SW-1:0] v_p   [RW];
  logic [SW-1:0] res_p [RW];
  logic [SW-1:0] op_p  [RW];

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_step
      localparam logic [SW-1:0] BIT = SW'(1) << (2 * (RW - 1 - k));
      logic [SW-1:0] v_in, res_in, op_in, tmp, v_next, res_next;

      if (k == 0) begin : g_first
        assign v_in   = operand;
        assign res_in = '0;
        assign op_in  = operand;
      end else begin : g_rest
        assign v_in   = v_p[k-1];
        assign res_in = res_p[k-1];
        assign op_in  = op_p[k-1];
      end

      always_comb begin
        tmp = res_in + BIT;
        if (v_in >= tmp) begin
          v_next   = v_in - tmp;
          res_next = (res_in >> 1) + BIT;
        end else begin
          v_next   = v_in;
          res_next = res_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          v_p[k]   <= v_next;
          res_p[k] <= res_next;
          op_p[k]  <= op_in;
        end
      end
    end
  endgenerate

  assign root        = res_p[RW-1][RW-1:0];
  assign operand_out = op_p[RW-1];

endmodule

/* design/cnbw_div.sv */
module cnbw_div
  import cnbw_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = T_W,
  parameter int QW = WRAW_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_p [QW];
  logic [DW-1:0] den_p [QW];
  logic [QW-1:0] q_p   [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_step
      localparam int SH = QW - 1 - k;
      localparam logic [QW-1:0] QBIT = QW'(1) << SH;
      logic [CW-1:0] rem_in, dsh, rem_next;
      logic [DW-1:0] den_in;
      logic [QW-1:0] q_in, q_next;

      if (k == 0) begin : g_first
        assign rem_in = CW'(num);
        assign den_in = den;
        assign q_in   = '0;
      end else begin : g_rest
        assign rem_in = rem_p[k-1];
        assign den_in = den_p[k-1];
        assign q_in   = q_p[k-1];
      end

      always_comb begin
        dsh = CW'(den_in) << SH;
        if (rem_in >= dsh) begin
          rem_next = rem_in - dsh;
          q_next   = q_in | QBIT;
        end else begin
          rem_next = rem_in;
          q_next   = q_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_p[k] <= rem_next;
          den_p[k] <= den_in;
          q_p[k]   <= q_next;
        end
      end
    end
  endgenerate

  assign quo = q_p[QW-1];

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cnbw_pkg::*;

  localparam int FRAC = COORD_FRAC_BITS_DEF;
  localparam int MAX_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  logic [67:0] weights_q[$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int          rx_hold = 0;

  cellular_noise_biome_weights u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] hash_cell(logic [31:0] cx, logic [31:0] cz);
    logic [31:0] h;
    h = cx * HASH_A + cz * HASH_B;
    h = (h ^ 32'($signed(h) >>> 13)) * HASH_C;
    return h ^ 32'($signed(h) >>> 16);
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [67:0] blend_weights(logic [31:0] px, logic [31:0] pz);
    longint      fx, fz, dx, dz;
    logic [31:0] cellx, cellz, h;
    logic [63:0] nearest[4];
    logic [63:0] w[4];
    logic [63:0] d, s, r, sum, q;
    bit          seen[4];
    logic [67:0] res;
    int          b;
    fx = longint'(px[FRAC-1:0]) << (WORK_FRAC - FRAC);
    fz = longint'(pz[FRAC-1:0]) << (WORK_FRAC - FRAC);
    cellx = 32'($signed(px) >>> FRAC);
    cellz = 32'($signed(pz) >>> FRAC);
    sum = 0;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      seen[i] = 0;
      nearest[i] = 0;
      w[i] = 0;
    end
    for (int ddz = -1; ddz <= 1; ddz++) begin
      for (int ddx = -1; ddx <= 1; ddx++) begin
        h = hash_cell(cellx + 32'(ddx), cellz + 32'(ddz));
        dx = longint'(ddx) * (64'sd1 << WORK_FRAC) + (longint'(h[15:0]) << 8) - fx;
        dz = longint'(ddz) * (64'sd1 << WORK_FRAC) + (longint'(h[31:16]) << 8) - fz;
        d = 64'(dx * dx) + 64'(dz * dz);
        b = h[1:0];
        if (!seen[b] || d < nearest[b]) begin
          nearest[b] = d;
          seen[b] = 1;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (seen[i]) begin
        s = (nearest[i] >> 16) + 64'(EPS_Q32);
        r = sqrt_floor(s);
        w[i] = RAW_NUM / (s * r);
        sum = sum + w[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      q = (w[i] << 16) / sum;
      if (q > 64'd65536) q = 64'd65536;
      res[i*17 +: 17] = q[16:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("** cellular_noise_biome_weights: FAILED **");
      $finish;
    end
    if (!rst && s_tvalid && s_tready)
      weights_q = {weights_q, blend_weights(s_tdata[31:0], s_tdata[63:32])};
    if (!rst && m_tvalid && m_tready) begin
      if (weights_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, m_tdata[67:0]);
        errors++;
      end else begin
        logic [67:0] exp_w;
        exp_w = weights_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (exp_w[i*17 +: 17] !== m_tdata[i*17 +: 17]) begin
            $display("%0t: weight_%0d expected %0d actual %0d", $time, i,
                     exp_w[i*17 +: 17], m_tdata[i*17 +: 17]);
            errors++;
          end
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (g > 0) begin
        m_tready = 1'b0;
        g--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(3) == 0) g = gap_len();
      end
    end
  end

  bit tx_gaps = 1;

  task automatic send_point(logic [31:0] px, logic [31:0] pz);
    int n;
    s_tdata = {pz, px};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    n = tx_gaps ? gap_len() : 0;
    if (n > 0) begin
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (weights_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    int p;
    p = $urandom_range(9);
    if (p < 6) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    return $urandom;
  endfunction

  task automatic test_directed();
    logic [31:0] pts[] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                           32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
    foreach (pts[i]) send_point(pts[i], pts[(i * 3 + 1) % pts.size()]);
    foreach (pts[i]) send_point(pts[(i + 5) % pts.size()], pts[i]);
    send_point(32'hAAAA_AAAA, 32'h5555_5555);
    send_point(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random(int count);
    repeat (count) send_point(rand_coord(), rand_coord());
  endtask

  task automatic test_backpressure();
    tx_gaps = 0;
    rx_hold = 300;
    test_random(200);
    tx_gaps = 1;
  endtask

  task automatic test_pause();
    drain();
    test_random(50);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(300);
    test_backpressure();
    test_pause();
    tx_gaps = 0;
    test_random(150);
    tx_gaps = 1;
    test_random(100);
    drain();
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0 && weights_q.size() == 0)
      $display("** cellular_noise_biome_weights: PASSED **");
    else
      $display("** cellular_noise_biome_weights: FAILED **");
    $finish;
  end

endmodule
